// ===== src/ptw_pkg.sv =====
`default_nettype none

package ptw_pkg;

  localparam logic CMD_REQUEST  = 1'b0;
  localparam logic CMD_RESPONSE = 1'b1;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [31:0] BASE_RESET = 32'h0000_4000;
  localparam logic [31:0] FAULT_ADDR = 32'hffff_ffff;

  localparam logic [1:0] DESC_FAULT   = 2'd0;
  localparam logic [1:0] DESC_TABLE   = 2'd1;
  localparam logic [1:0] DESC_SECTION = 2'd2;
  localparam int         SUPER_BIT    = 18;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_L1   = 2'd1,
    PH_L2   = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    JOB_L1_READ = 3'd0,
    JOB_L2_READ = 3'd1,
    JOB_FAULT   = 3'd2,
    JOB_SECTION = 3'd3,
    JOB_SUPER   = 3'd4,
    JOB_PAGE4K  = 3'd5,
    JOB_PAGE64K = 3'd6
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [31:0] desc;
    logic [31:0] va;
  } job_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] mem_addr;
    logic [31:0] phys_addr;
    logic        fault;
  } result_t;

endpackage

`default_nettype wire

// ===== src/page_table_walker.sv =====
// Channel   Handshake            Payload
// input     push / full          cmd, virt_addr, read_data
// result    pop / empty          kind, mem_addr, phys_addr, fault
// config    cfg_valid/cfg_ready  cfg_data (l1_table_base)
//
// One item per cycle while full is low; an accepted item that yields a result passes the two
// queue stages, job queue then result queue, before that result shows on the result ports.
// Reset (rst, synchronous) empties both queues, ends any walk, table base 0x4000.
// A full result queue stalls the back end; the job queue then fills and raises full.
`default_nettype none

module page_table_walker #(
  parameter int JOB_DEPTH = 2,
  parameter int OUT_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data,
  input  wire logic        push,
  output logic             full,
  input  wire logic        cmd,
  input  wire logic [31:0] virt_addr,
  input  wire logic [31:0] read_data,
  output logic             empty,
  input  wire logic        pop,
  output logic             kind,
  output logic [31:0]      mem_addr,
  output logic [31:0]      phys_addr,
  output logic             fault
);

  ptw_pkg::job_t    job_in;
  ptw_pkg::job_t    job_out;
  ptw_pkg::result_t res_in;
  ptw_pkg::result_t res_out;
  logic             job_push;
  logic             job_full;
  logic             job_empty;
  logic             job_pop;
  logic             res_push;
  logic             res_full;
  logic             accept;

  assign full   = job_full;
  assign accept = push && !job_full;

  ptw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .cmd       (cmd),
    .virt_addr (virt_addr),
    .read_data (read_data),
    .job_push  (job_push),
    .job       (job_in)
  );

  ptw_fifo #(
    .WIDTH ($bits(ptw_pkg::job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .din   (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .dout  (job_out),
    .empty (job_empty)
  );

  ptw_back u_back (
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  ptw_fifo #(
    .WIDTH ($bits(ptw_pkg::result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign kind      = res_out.kind;
  assign mem_addr  = res_out.mem_addr;
  assign phys_addr = res_out.phys_addr;
  assign fault     = res_out.fault;

endmodule

`default_nettype wire

// ===== src/ptw_fifo.sv =====
`default_nettype none

module ptw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/ptw_front.sv =====
`default_nettype none

module ptw_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [31:0]   cfg_data,
  input  wire logic          accept,
  input  wire logic          cmd,
  input  wire logic [31:0]   virt_addr,
  input  wire logic [31:0]   read_data,
  output logic               job_push,
  output ptw_pkg::job_t      job
);

  logic [31:0]     l1_table_base;
  ptw_pkg::phase_t walk_phase;
  ptw_pkg::phase_t walk_phase_next;
  logic [31:0]     saved_vaddr;
  logic [31:0]     saved_vaddr_next;
  logic            has_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      l1_table_base <= ptw_pkg::BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      l1_table_base <= cfg_data;
    end
  end

  always_comb begin
    walk_phase_next  = walk_phase;
    saved_vaddr_next = saved_vaddr;
    has_job          = 1'b0;
    job.kind         = ptw_pkg::JOB_FAULT;
    job.desc         = read_data;
    job.va           = saved_vaddr;
    if (cmd == ptw_pkg::CMD_REQUEST) begin
      if (walk_phase != ptw_pkg::PH_L1 && walk_phase != ptw_pkg::PH_L2) begin
        has_job          = 1'b1;
        job.kind         = ptw_pkg::JOB_L1_READ;
        job.desc         = l1_table_base;
        job.va           = virt_addr;
        saved_vaddr_next = virt_addr;
        walk_phase_next  = ptw_pkg::PH_L1;
      end
    end else begin
      case (walk_phase)
        ptw_pkg::PH_L1: begin
          has_job         = 1'b1;
          walk_phase_next = ptw_pkg::PH_IDLE;
          if (read_data[1:0] == ptw_pkg::DESC_TABLE) begin
            job.kind        = ptw_pkg::JOB_L2_READ;
            walk_phase_next = ptw_pkg::PH_L2;
          end else if (read_data[1:0] == ptw_pkg::DESC_SECTION) begin
            job.kind = read_data[ptw_pkg::SUPER_BIT] ? ptw_pkg::JOB_SUPER
                                                     : ptw_pkg::JOB_SECTION;
          end else begin
            job.kind = ptw_pkg::JOB_FAULT;
          end
        end
        ptw_pkg::PH_L2: begin
          has_job         = 1'b1;
          walk_phase_next = ptw_pkg::PH_IDLE;
          if (read_data[1:0] == ptw_pkg::DESC_FAULT) begin
            job.kind = ptw_pkg::JOB_FAULT;
          end else if (read_data[1]) begin
            job.kind = ptw_pkg::JOB_PAGE4K;
          end else begin
            job.kind = ptw_pkg::JOB_PAGE64K;
          end
        end
        default: begin
          walk_phase_next = ptw_pkg::PH_IDLE;
        end
      endcase
    end
  end

  assign job_push = accept && has_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_phase  <= ptw_pkg::PH_IDLE;
      saved_vaddr <= '0;
    end else if (accept) begin
      walk_phase  <= walk_phase_next;
      saved_vaddr <= saved_vaddr_next;
    end
  end

  a_push_needs_accept: assert property (@(posedge clk) disable iff (rst)
    job_push |-> accept)
    else $error("job pushed without an accepted item");

  a_request_starts_walk: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == ptw_pkg::CMD_REQUEST && walk_phase == ptw_pkg::PH_IDLE
    |=> walk_phase == ptw_pkg::PH_L1 && saved_vaddr == $past(virt_addr))
    else $error("request did not start a walk");

  a_l2_ends_walk: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == ptw_pkg::CMD_RESPONSE && walk_phase == ptw_pkg::PH_L2
    |=> walk_phase == ptw_pkg::PH_IDLE)
    else $error("second-level response did not end the walk");

endmodule

`default_nettype wire

// ===== src/ptw_back.sv =====
`default_nettype none

module ptw_back (
  input  wire logic          job_empty,
  input  wire ptw_pkg::job_t job,
  output logic               job_pop,
  input  wire logic          res_full,
  output logic               res_push,
  output ptw_pkg::result_t   res
);

  assign job_pop  = !job_empty && !res_full;
  assign res_push = job_pop;

  always_comb begin
    res.kind      = ptw_pkg::KIND_DONE;
    res.mem_addr  = '0;
    res.phys_addr = '0;
    res.fault     = 1'b0;
    case (job.kind)
      ptw_pkg::JOB_L1_READ: begin
        res.kind     = ptw_pkg::KIND_READ;
        res.mem_addr = job.desc + {18'd0, job.va[31:20], 2'b00};
      end
      ptw_pkg::JOB_L2_READ: begin
        res.kind     = ptw_pkg::KIND_READ;
        res.mem_addr = {job.desc[31:10], 10'd0} + {22'd0, job.va[19:12], 2'b00};
      end
      ptw_pkg::JOB_SECTION: res.phys_addr = {job.desc[31:20], job.va[19:0]};
      ptw_pkg::JOB_SUPER:   res.phys_addr = {job.desc[31:24], job.va[23:0]};
      ptw_pkg::JOB_PAGE4K:  res.phys_addr = {job.desc[31:12], job.va[11:0]};
      ptw_pkg::JOB_PAGE64K: res.phys_addr = {job.desc[31:16], job.va[15:0]};
      default: begin
        res.phys_addr = ptw_pkg::FAULT_ADDR;
        res.fault     = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none

module testbench;

  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT   = 400000;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  logic        push;
  logic        full;
  logic        cmd;
  logic [31:0] virt_addr;
  logic [31:0] read_data;
  logic        empty;
  logic        pop;
  logic        kind;
  logic [31:0] mem_addr;
  logic [31:0] phys_addr;
  logic        fault;

  page_table_walker dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .cmd       (cmd),
    .virt_addr (virt_addr),
    .read_data (read_data),
    .empty     (empty),
    .pop       (pop),
    .kind      (kind),
    .mem_addr  (mem_addr),
    .phys_addr (phys_addr),
    .fault     (fault)
  );

  ptw_pkg::phase_t  model_phase;
  logic [31:0]      model_va;
  logic [31:0]      model_base;
  ptw_pkg::result_t awaited_results[$];
  int               errors;
  int               cycles;
  bit               send_idle;
  bit               recv_idle;
  int               hold_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  function automatic void step_walker(input logic c, input logic [31:0] va_in,
                                      input logic [31:0] d);
    ptw_pkg::result_t r;
    r = '0;
    if (c == ptw_pkg::CMD_REQUEST) begin
      if (model_phase != ptw_pkg::PH_IDLE) return;
      model_va = va_in;
      model_phase = ptw_pkg::PH_L1;
      r.kind = ptw_pkg::KIND_READ;
      r.mem_addr = model_base + {18'd0, va_in[31:20], 2'b00};
    end else if (model_phase == ptw_pkg::PH_L1) begin
      r.kind = ptw_pkg::KIND_DONE;
      if (d[1:0] == ptw_pkg::DESC_TABLE) begin
        r.kind = ptw_pkg::KIND_READ;
        r.mem_addr = {d[31:10], 10'd0} + {22'd0, model_va[19:12], 2'b00};
        model_phase = ptw_pkg::PH_L2;
      end else if (d[1:0] == ptw_pkg::DESC_SECTION) begin
        r.phys_addr = d[ptw_pkg::SUPER_BIT] ? {d[31:24], model_va[23:0]}
                                            : {d[31:20], model_va[19:0]};
      end else begin
        r.phys_addr = ptw_pkg::FAULT_ADDR;
        r.fault = 1'b1;
      end
      if (r.kind == ptw_pkg::KIND_DONE) model_phase = ptw_pkg::PH_IDLE;
    end else if (model_phase == ptw_pkg::PH_L2) begin
      r.kind = ptw_pkg::KIND_DONE;
      if (d[1:0] == ptw_pkg::DESC_FAULT) begin
        r.phys_addr = ptw_pkg::FAULT_ADDR;
        r.fault = 1'b1;
      end else if (d[1]) begin
        r.phys_addr = {d[31:12], model_va[11:0]};
      end else begin
        r.phys_addr = {d[31:16], model_va[15:0]};
      end
      model_phase = ptw_pkg::PH_IDLE;
    end else begin
      model_phase = ptw_pkg::PH_IDLE;
      return;
    end
    awaited_results.push_back(r);
  endfunction

  always @(posedge clk) begin
    ptw_pkg::result_t want;
    if (!rst && pop && !empty) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: kind %0d mem_addr %h phys_addr %h fault %0d",
               kind, mem_addr, phys_addr, fault);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, kind);
          errors++;
        end
        if (mem_addr !== want.mem_addr) begin
          $error("mem_addr: expected %h, actual %h", want.mem_addr, mem_addr);
          errors++;
        end
        if (phys_addr !== want.phys_addr) begin
          $error("phys_addr: expected %h, actual %h", want.phys_addr, phys_addr);
          errors++;
        end
        if (fault !== want.fault) begin
          $error("fault: expected %0d, actual %0d", want.fault, fault);
          errors++;
        end
      end
    end
  end

  initial begin
    int gap;
    pop = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        gap = hold_cycles;
        hold_cycles = 0;
      end else begin
        gap = recv_idle ? $urandom_range(0, 13) : 0;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_item(input logic c, input logic [31:0] va, input logic [31:0] d);
    int gap;
    gap = send_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    cmd <= c;
    virt_addr <= va;
    read_data <= d;
    @(posedge clk);
    while (full) @(posedge clk);
    step_walker(c, va, d);
    @(negedge clk);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_table_base(input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_base = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_walk(input logic [31:0] va, input logic [31:0] l1,
                          input logic [31:0] l2);
    // finish any walk left open by a stray item
    while (model_phase != ptw_pkg::PH_IDLE)
      send_item(ptw_pkg::CMD_RESPONSE, $urandom(), $urandom());
    send_item(ptw_pkg::CMD_REQUEST, va, $urandom());
    send_item(ptw_pkg::CMD_RESPONSE, $urandom(), l1);
    if (l1[1:0] == ptw_pkg::DESC_TABLE) send_item(ptw_pkg::CMD_RESPONSE, $urandom(), l2);
  endtask

  task automatic test_directed();
    send_item(ptw_pkg::CMD_RESPONSE, $urandom(), $urandom());
    run_walk(32'h0000_0000, 32'hfff0_0002, 32'h0);
    run_walk(32'hffff_ffff, 32'hff04_0002, 32'h0);
    run_walk(32'h1234_5678, 32'h0000_0000, 32'h0);
    run_walk(32'h8000_0000, 32'hffff_ffff, 32'h0);
    run_walk(32'hffff_ffff, 32'hffff_fc01, 32'hffff_f002);
    run_walk(32'h0000_0000, 32'h0000_0001, 32'hffff_0001);
    run_walk(32'h7654_3210, 32'h5555_5401, 32'h0000_0000);
    run_walk(32'hdead_beef, 32'haaaa_a801, 32'hffff_ffff);
    // request arriving mid-walk is dropped
    send_item(ptw_pkg::CMD_REQUEST, 32'h0abc_d123, $urandom());
    send_item(ptw_pkg::CMD_RESPONSE, $urandom(), 32'h1357_9c01);
    send_item(ptw_pkg::CMD_REQUEST, 32'hf0f0_f0f0, $urandom());
    send_item(ptw_pkg::CMD_RESPONSE, $urandom(), 32'h2468_ace1);
  endtask

  task automatic test_table_base();
    logic [31:0] bases [4];
    bases = '{32'h0000_0000, 32'hffff_c000, 32'hffff_ffff, 32'h0000_1235};
    foreach (bases[i]) begin
      drain();
      write_table_base(bases[i]);
      run_walk(32'h0000_0000, $urandom(), $urandom());
      run_walk(32'hffff_ffff, $urandom(), $urandom());
      run_walk($urandom(), $urandom(), $urandom());
    end
  endtask

  task automatic test_backpressure();
    drain();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    hold_cycles = 150;
    repeat (16) run_walk($urandom(), $urandom(), $urandom());
    drain();
    recv_idle = 1'b1;
    repeat (8) run_walk($urandom(), $urandom(), $urandom());
    drain();
    repeat (8) run_walk($urandom(), $urandom(), $urandom());
    send_idle = 1'b1;
  endtask

  task automatic test_random_walks();
    for (int p = 0; p < 5; p++) begin
      drain();
      case (p)
        0: write_table_base($urandom() & 32'hffff_c000);
        1: write_table_base($urandom());
        4: write_table_base(ptw_pkg::BASE_RESET);
        default: write_table_base($urandom() & 32'hffff_c000);
      endcase
      send_idle = $urandom_range(0, 3) != 0;
      recv_idle = $urandom_range(0, 3) != 0;
      repeat (52) begin
        if ($urandom_range(0, 6) == 0) begin
          repeat ($urandom_range(1, 3))
            send_item(1'($urandom_range(0, 1)), $urandom(), $urandom());
        end else begin
          run_walk($urandom(), $urandom(), $urandom());
        end
      end
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    push = 1'b0;
    cmd = ptw_pkg::CMD_REQUEST;
    virt_addr = '0;
    read_data = '0;
    model_phase = ptw_pkg::PH_IDLE;
    model_va = '0;
    model_base = ptw_pkg::BASE_RESET;
    errors = 0;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    hold_cycles = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_table_base();
    test_backpressure();
    test_random_walks();

    drain();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
